>>> src/ffcf_pkg.sv
// Shared constants, types and state codes of the farthest free cell finder.
`timescale 1ns / 1ps
`default_nettype none
package ffcf_pkg;

	localparam int MAX_SIDE = 64;
	localparam int MAX_CARS = 4096;

	localparam int POS_W   = 7;
	localparam int SIDE_W  = 7;
	localparam int TOT_W   = 13;
	localparam int COORD_W = $clog2(MAX_SIDE);
	localparam int CELL_W  = 2 * COORD_W;
	localparam int CELLS   = MAX_SIDE * MAX_SIDE;
	localparam int CAR_AW  = $clog2(MAX_CARS);
	localparam int CAR_CW  = CAR_AW + 1;
	localparam int DIST_W  = COORD_W + 1;

	localparam int CFG_AW = 3;
	localparam int CFG_DW = 32;

	localparam logic [SIDE_W-1:0] SIDE_RESET  = SIDE_W'(50);
	localparam logic [TOT_W-1:0]  TOTAL_LIMIT = '1;

	localparam logic REG_GRID_SIDE = 1'b0;

	localparam logic OP_ADD   = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_ADD,
		ST_QCELL,
		ST_QOCC,
		ST_QCAR,
		ST_QCMP,
		ST_DONE
	} st_t;

	typedef struct packed {
		logic [POS_W-1:0] x;
		logic [POS_W-1:0] y;
	} res_t;

endpackage
`default_nettype wire

>>> src/ffcf_ram.sv
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none
module ffcf_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 2
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule
`default_nettype wire

>>> src/ffcf_cfg.sv
// Configuration register port holding the grid side.
`timescale 1ns / 1ps
`default_nettype none
module ffcf_cfg (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ffcf_pkg::CFG_AW-1:0] paddr,
	input  wire logic [ffcf_pkg::CFG_DW-1:0] pwdata,
	output logic      [ffcf_pkg::CFG_DW-1:0] prdata,
	output logic                             pready,
	output logic      [ffcf_pkg::SIDE_W-1:0] side
);
	import ffcf_pkg::*;

	logic [SIDE_W-1:0] grid_side_q;
	logic              reg_idx;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[CFG_AW-1];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_side_q <= SIDE_RESET;
		end else if (wr_en && reg_idx == REG_GRID_SIDE) begin
			grid_side_q <= pwdata[SIDE_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_GRID_SIDE) begin
			prdata = CFG_DW'(grid_side_q);
		end
	end

	// clamp to 1..MAX_SIDE
	always_comb begin
		priority if (grid_side_q == '0) begin
			side = SIDE_W'(1);
		end else if (grid_side_q > SIDE_W'(MAX_SIDE)) begin
			side = SIDE_W'(MAX_SIDE);
		end else begin
			side = grid_side_q;
		end
	end

endmodule
`default_nettype wire

>>> src/ffcf_core.sv
// Sequencer and datapath over the occupancy and car position memories.
`timescale 1ns / 1ps
`default_nettype none
module ffcf_core (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic [ffcf_pkg::SIDE_W-1:0] side,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic                       op,
	input  wire logic [ffcf_pkg::POS_W-1:0] pos_x,
	input  wire logic [ffcf_pkg::POS_W-1:0] pos_y,
	output logic                            res_valid,
	input  wire logic                       res_take,
	output ffcf_pkg::res_t                  res
);
	import ffcf_pkg::*;

	st_t st_q, st_d;

	logic [COORD_W-1:0]  cx_q, cy_q, bx_q, by_q, side_m1;
	logic [CAR_CW-1:0]   k_q, cars_q;
	logic [TOT_W-1:0]    tot_q;
	logic [DIST_W-1:0]   near_q, best_q, car_dist, near_min;
	logic                found_q;
	logic [CELL_W-1:0]   clr_q, cell_q, in_cell;
	logic                rng_q, in_rng;
	logic [2*SIDE_W-1:0] side_sq;
	logic                full, last_cell, accept, new_car;

	logic                occ_we, occ_wdata, occ_rdata;
	logic [CELL_W-1:0]   occ_waddr, occ_raddr;
	logic                car_we;
	logic [CAR_AW-1:0]   car_raddr;
	logic [CELL_W-1:0]   car_rdata;

	function automatic logic [COORD_W-1:0] adiff(logic [COORD_W-1:0] a, logic [COORD_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	ffcf_ram #(.WIDTH(1), .DEPTH(CELLS)) u_occ (
		.clk   (clk),
		.we    (occ_we),
		.waddr (occ_waddr),
		.wdata (occ_wdata),
		.raddr (occ_raddr),
		.rdata (occ_rdata)
	);

	ffcf_ram #(.WIDTH(CELL_W), .DEPTH(MAX_CARS)) u_car (
		.clk   (clk),
		.we    (car_we),
		.waddr (cars_q[CAR_AW-1:0]),
		.wdata (cell_q),
		.raddr (car_raddr),
		.rdata (car_rdata)
	);

	assign in_rng    = pos_x != '0 && pos_x <= side && pos_y != '0 && pos_y <= side;
	assign in_cell   = {COORD_W'(pos_x - POS_W'(1)), COORD_W'(pos_y - POS_W'(1))};
	assign side_m1   = COORD_W'(side - SIDE_W'(1));
	assign side_sq   = {{SIDE_W{1'b0}}, side} * {{SIDE_W{1'b0}}, side};
	assign full      = {{(2*SIDE_W-TOT_W){1'b0}}, tot_q} >= side_sq;
	assign last_cell = cx_q == side_m1 && cy_q == side_m1;
	assign accept    = in_valid && in_ready;
	assign new_car   = rng_q && !occ_rdata && cars_q != CAR_CW'(MAX_CARS);

	assign car_dist = {1'b0, adiff(car_rdata[CELL_W-1:COORD_W], cx_q)}
		+ {1'b0, adiff(car_rdata[COORD_W-1:0], cy_q)};
	assign near_min = (car_dist < near_q) ? car_dist : near_q;

	assign res.x = found_q ? POS_W'(bx_q) + POS_W'(1) : '0;
	assign res.y = found_q ? POS_W'(by_q) + POS_W'(1) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_CLEAR;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d      = st_q;
		in_ready  = 1'b0;
		res_valid = 1'b0;
		occ_we    = 1'b0;
		occ_waddr = clr_q;
		occ_wdata = 1'b0;
		occ_raddr = {cx_q, cy_q};
		car_we    = 1'b0;
		car_raddr = k_q[CAR_AW-1:0];
		unique case (st_q)
			ST_CLEAR: begin
				occ_we = 1'b1;
				if (&clr_q) begin
					st_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready  = 1'b1;
				occ_raddr = in_cell;
				if (in_valid) begin
					priority if (op == OP_ADD) begin
						st_d = ST_ADD;
					end else if (full || cars_q == '0) begin
						st_d = ST_DONE;
					end else begin
						st_d = ST_QCELL;
					end
				end
			end
			ST_ADD: begin
				st_d = ST_IDLE;
				if (new_car) begin
					occ_we    = 1'b1;
					occ_waddr = cell_q;
					occ_wdata = 1'b1;
					car_we    = 1'b1;
				end
			end
			ST_QCELL: begin
				st_d = ST_QOCC;
			end
			ST_QOCC: begin
				if (occ_rdata) begin
					st_d = last_cell ? ST_DONE : ST_QCELL;
				end else begin
					car_raddr = '0;
					st_d      = ST_QCAR;
				end
			end
			ST_QCAR: begin
				if (k_q == cars_q) begin
					st_d = ST_QCMP;
				end
			end
			ST_QCMP: begin
				st_d = last_cell ? ST_DONE : ST_QCELL;
			end
			ST_DONE: begin
				res_valid = 1'b1;
				if (res_take) begin
					st_d = ST_CLEAR;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			tot_q  <= '0;
			cars_q <= '0;
		end else begin
			if (st_q == ST_CLEAR) begin
				clr_q <= clr_q + CELL_W'(1);
			end
			if (accept && op == OP_ADD && tot_q != TOTAL_LIMIT) begin
				tot_q <= tot_q + TOT_W'(1);
			end
			if (car_we) begin
				cars_q <= cars_q + CAR_CW'(1);
			end
			if (st_q == ST_DONE && res_take) begin
				tot_q  <= '0;
				cars_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cell_q  <= in_cell;
			rng_q   <= in_rng;
			cx_q    <= '0;
			cy_q    <= '0;
			bx_q    <= '0;
			by_q    <= '0;
			found_q <= !full && cars_q == '0;
		end
		if (st_q == ST_QOCC) begin
			k_q    <= CAR_CW'(1);
			near_q <= '1;
		end
		if (st_q == ST_QCAR) begin
			near_q <= near_min;
			if (k_q != cars_q) begin
				k_q <= k_q + CAR_CW'(1);
			end
		end
		if (st_q == ST_QCMP && (!found_q || near_q > best_q)) begin
			found_q <= 1'b1;
			best_q  <= near_q;
			bx_q    <= cx_q;
			by_q    <= cy_q;
		end
		// advance to the next cell, column by column
		if ((st_q == ST_QOCC && occ_rdata) || st_q == ST_QCMP) begin
			if (cy_q == side_m1) begin
				cy_q <= '0;
				cx_q <= cx_q + COORD_W'(1);
			end else begin
				cy_q <= cy_q + COORD_W'(1);
			end
		end
	end

endmodule
`default_nettype wire

>>> src/farthest_free_cell_finder.sv
// Top level of the farthest free cell finder: config port, core and output register.
//
//  channel   | direction | handshake           | word
//  ----------+-----------+---------------------+---------------------------
//  config    | in        | psel/penable/pready | grid_side at byte address 0
//  in        | in        | in_valid/in_ready   | op, pos_x, pos_y
//  out       | out       | out_valid/out_ready | best_x, best_y
//
// An add reads the occupancy memory, then conditionally writes the cell and the car position.
// A query sweeps the side*side cells: an occupied cell is skipped after its occupancy read,
// and a free cell reads every car position in turn through the single read port of the car
// position memory.
// After reset and after each answer the occupancy memory is cleared cell by cell, and no
// word is taken meanwhile. A stalled output holds the block only at a finished query.
`timescale 1ns / 1ps
`default_nettype none
module farthest_free_cell_finder (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [ffcf_pkg::CFG_AW-1:0] paddr,
	input  wire logic [ffcf_pkg::CFG_DW-1:0] pwdata,
	output logic      [ffcf_pkg::CFG_DW-1:0] prdata,
	output logic                             pready,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic                        op,
	input  wire logic [ffcf_pkg::POS_W-1:0]  pos_x,
	input  wire logic [ffcf_pkg::POS_W-1:0]  pos_y,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic      [ffcf_pkg::POS_W-1:0]  best_x,
	output logic      [ffcf_pkg::POS_W-1:0]  best_y
);
	import ffcf_pkg::*;

	logic [SIDE_W-1:0] side;
	logic              res_valid, res_take;
	res_t              res;
	logic              out_valid_q;
	logic [POS_W-1:0]  best_x_q, best_y_q;

	ffcf_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.side    (side)
	);

	ffcf_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.side      (side),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.op        (op),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.res_valid (res_valid),
		.res_take  (res_take),
		.res       (res)
	);

	assign res_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid && res_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_take) begin
			best_x_q <= res.x;
			best_y_q <= res.y;
		end
	end

	assign out_valid = out_valid_q;
	assign best_x    = best_x_q;
	assign best_y    = best_y_q;

	a_word_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("input taken on two consecutive cycles");

	a_res_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !in_ready)
		else $error("input ready while a result is pending");

	a_res_load: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_take |=> out_valid && best_x == $past(res.x) && best_y == $past(res.y))
		else $error("result not moved into output register");

	a_full_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && best_x == '0 |-> best_y == '0)
		else $error("partial zero result");

endmodule
`default_nettype wire
